FILE: sv/dcwg_pkg.sv
// Shared types and constants for the dual channel waveform generator.
// No dependencies; imported by the state RAM, divider, top level and bench.
`timescale 1ns / 1ps
`default_nettype none

package dcwg_pkg;

  // serial divider sizing
  localparam int unsigned DivW  = 34;
  localparam int unsigned QuoW  = 18;
  localparam int unsigned StepW = 5;

  // field widths
  localparam int unsigned TypeW = 3;
  localparam int unsigned AmpW  = 11;
  localparam int unsigned FreqW = 16;
  localparam int unsigned SmpW  = 8;
  localparam int unsigned PhW   = 9;
  localparam int unsigned HoldW = 10;
  localparam int unsigned LenW  = 9;

  // wave type codes
  localparam logic [TypeW-1:0] WaveSine     = 3'd1;
  localparam logic [TypeW-1:0] WaveSquare   = 3'd2;
  localparam logic [TypeW-1:0] WaveTriangle = 3'd3;
  localparam logic [TypeW-1:0] WaveSaw      = 3'd4;
  localparam logic [TypeW-1:0] WaveRevSaw   = 3'd5;

  // register field selects (index bit 2 picks the channel)
  localparam logic [1:0] RegType = 2'd0;
  localparam logic [1:0] RegAmp  = 2'd1;
  localparam logic [1:0] RegOff  = 2'd2;
  localparam logic [1:0] RegFreq = 2'd3;

  // derivation and scaling constants
  localparam logic [FreqW-1:0] BaseRate  = 16'd410;
  localparam logic [DivW-1:0]  FastNum   = 34'd104960;
  localparam logic [DivW-1:0]  SearchNum = 34'd104550;
  localparam logic signed [40:0] ScaleLim  = 41'sd5033164800;
  localparam logic signed [40:0] RoundBias = 41'sd9830400;
  // scale divisor is 150 << 17; x / 150 for x below 38400 is (x * RecipMul) >> 23
  localparam logic [15:0]      RecipMul  = 16'd55925;
  localparam logic [22:0]      OffMul    = 23'd8323072;
  localparam logic [SmpW-1:0]  MidCode   = 8'd127;
  localparam logic [SmpW-1:0]  FullCode  = 8'd255;
  localparam logic [StepW-1:0] ShapeSteps  = 5'd18;
  localparam logic [StepW-1:0] DeriveSteps = 5'd9;

  // per channel state word kept in the state RAM
  typedef struct packed {
    logic [SmpW-1:0]  held;
    logic [HoldW-1:0] reload;
    logic [LenW-1:0]  len;
    logic [HoldW-1:0] hold;
    logic [PhW-1:0]   phase;
  } ch_state_t;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dend;
    logic [DivW-1:0]  dsor;
    logic [StepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TRD,
    ST_TEVAL,
    ST_TDIV,
    ST_TROM,
    ST_TMUL,
    ST_TSCALE,
    ST_TFIN,
    ST_TWR,
    ST_OUT,
    ST_DRD,
    ST_DSTART,
    ST_DDIV1,
    ST_DMUL,
    ST_DDIV2S,
    ST_DDIV2,
    ST_DWR
  } ctl_state_e;

endpackage

`default_nettype wire

FILE: sv/dcwg_state_ram.sv
// Two entry state RAM, one word per channel, registered read.
// Depends on dcwg_pkg for the state word type.
`timescale 1ns / 1ps
`default_nettype none

module dcwg_state_ram (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic               waddr_i,
  input  dcwg_pkg::ch_state_t     wdata_i,
  input  wire logic               re_i,
  input  wire logic               raddr_i,
  output dcwg_pkg::ch_state_t     rdata_o
);
  import dcwg_pkg::*;

  ch_state_t mem_q [2];
  ch_state_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold the read word until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/dcwg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on dcwg_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none

module dcwg_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  dcwg_pkg::div_req_t req_i,
  output dcwg_pkg::div_rsp_t rsp_o
);
  import dcwg_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  dsh_q, dsh_d;
  logic [QuoW-1:0]  quo_q, quo_d;
  logic             ge;

  assign ge = (rem_q >= dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = req_i.steps;
      rem_d  = req_i.dend;
      dsh_d  = req_i.dsor << (req_i.steps - 5'd1);
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? rem_q - dsh_q : rem_q;
      quo_d = {quo_q[QuoW-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

FILE: sv/dcwg_sine_rom.sv
// Quarter wave sine ROM in unsigned Q0.15 with registered read.
// Entries are built at elaboration from a Q30 series; no package use.
`timescale 1ns / 1ps
`default_nettype none

module dcwg_sine_rom #(
  parameter int unsigned SINE_QUARTER_DEPTH = 256
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  re_i,
  input  wire logic [$clog2(SINE_QUARTER_DEPTH+1)-1:0] addr_i,
  output logic [14:0]                                data_o
);

  localparam int unsigned AddrW = $clog2(SINE_QUARTER_DEPTH + 1);

  function automatic logic [14:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    x    = (64'd1686629713 * 64'(k)) / 64'(SINE_QUARTER_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(term);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  logic [14:0] rom_w [SINE_QUARTER_DEPTH+1];
  logic [14:0] data_q;

  for (genvar k = 0; k <= SINE_QUARTER_DEPTH; k++) begin : g_rom
    assign rom_w[k] = sine_entry(k);
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      data_q <= rom_w[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: sv/dual_channel_waveform_generator_top.sv
// Two channel lookup table waveform generator: sine, square, triangle, saw and
// reverse saw, each scaled by amplitude and offset into an 8-bit DAC code.
// Depends on dcwg_pkg, dcwg_state_ram, dcwg_div and dcwg_sine_rom.
//
// Each input beat (tick) yields one output beat carrying both held codes. Per
// channel state sits in a two entry RAM that is read, updated and written back
// one channel after the other; one serial divider (a quotient bit per cycle)
// serves shape and period derivation, and scaling uses a reciprocal multiply.
// A tick is shortest when both channels are holding; a sample update can add the
// shape divide. After reset, and after any write to registers 0..7, both
// channels derive period and hold from frequency, with s_axis_tready_o low.
// Writes with index above 7 are ignored. Output beats wait in a register.
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_waveform_generator_top #(
  parameter int unsigned SINE_QUARTER_DEPTH = 256,
  parameter int unsigned MAX_HOLD           = 1000
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [0] tick
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] sample_a, [15:8] sample_b
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import dcwg_pkg::*;

  localparam int unsigned Q4    = 4 * SINE_QUARTER_DEPTH;
  localparam int unsigned QsW   = $clog2(Q4 + 1);
  localparam int unsigned RomAW = $clog2(SINE_QUARTER_DEPTH + 1);

  ctl_state_e state_q, state_d;

  // configuration
  logic [TypeW-1:0] type_q [2];
  logic [AmpW-1:0]  amp_q  [2];
  logic [AmpW-1:0]  off_q  [2];
  logic [FreqW-1:0] freq_q [2];

  logic             ch_q;
  logic             init_q;
  logic             tick_q;
  logic             upd_q;
  logic             sine_q;
  logic             neg_q;
  logic             fast_q;
  logic [PhW-1:0]   phase_q;
  logic [SmpW-1:0]  sample_q;
  logic signed [18:0] s_q;
  logic signed [30:0] prod_q;
  logic [15:0]      scl_q;
  logic [LenW-1:0]  len_q;
  logic [HoldW-1:0] rel_q;
  logic [8:0]       iq_q;
  logic [17:0]      fi_q;
  logic [SmpW-1:0]  smp_q [2];
  logic             out_valid_q;
  logic [15:0]      out_data_q;
  logic [RomAW-1:0] rom_addr_q;

  ch_state_t ent;
  ch_state_t ram_wdata;
  logic      ram_we;
  logic      ram_re;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic [14:0] rom_data;
  logic        rom_re;

  // ---- combinational datapath helpers ----
  logic [TypeW-1:0] cur_type;
  logic [AmpW-1:0]  cur_amp;
  logic [AmpW-1:0]  cur_off;
  logic [FreqW-1:0] cur_freq;
  logic [PhW-1:0]   phase_w;
  logic             hold_zero;
  logic             known_type;
  logic             sq_high;
  logic signed [11:0] li, ll, num_w;
  logic [11:0]      mag_w;
  logic [10:0]      tq_w;
  logic [34:0]      off_mul_w;
  logic signed [40:0] n2_w;
  logic [31:0]      recip_w;
  logic [QsW-1:0]   sq_w, p_w, k_w;
  logic [1:0]       quad_w;
  logic [RomAW-1:0] rom_addr_w;
  logic [10:0]      inext_w;
  logic             cfg_take;
  logic             in_take;
  logic             out_load;

  assign cur_type = type_q[ch_q];
  assign cur_amp  = amp_q[ch_q];
  assign cur_off  = off_q[ch_q];
  assign cur_freq = freq_q[ch_q];

  assign phase_w   = (ent.phase > ent.len) ? ent.phase - ent.len : ent.phase;
  assign hold_zero = (ent.hold == '0);
  assign known_type = (cur_type == WaveSine) || (cur_type == WaveSquare) ||
                      (cur_type == WaveTriangle) || (cur_type == WaveSaw) ||
                      (cur_type == WaveRevSaw);
  assign sq_high = (phase_w < (ent.len >> 1));
  assign li      = $signed({3'b000, phase_w});
  assign ll      = $signed({3'b000, ent.len});
  assign tq_w    = ({2'b00, ent.len} * 11'd3) >> 2;

  always_comb begin
    num_w = ll - (li <<< 1);
    if (cur_type == WaveTriangle) begin
      if (phase_w < (ent.len >> 2)) begin
        num_w = li <<< 2;
      end else if ({2'b00, phase_w} < tq_w) begin
        num_w = (ll <<< 1) - (li <<< 2);
      end else begin
        num_w = (li <<< 2) - (ll <<< 2);
      end
    end else if (cur_type == WaveSaw) begin
      num_w = sq_high ? (li <<< 1) : ((li <<< 1) - (ll <<< 1));
    end
  end

  assign mag_w = num_w[11] ? 12'(-num_w) : 12'(num_w);

  assign off_mul_w = 35'(cur_off) * 35'(OffMul);
  assign n2_w = (41'(prod_q) <<< 8) + $signed({6'b000000, off_mul_w}) + RoundBias;

  // quotient of the scaled value, known below 256
  assign recip_w = 32'(scl_q) * 32'(RecipMul);

  // sine phase to quadrant and table address
  assign sq_w = div_rsp.quo[QsW-1:0];
  assign p_w  = (sq_w == QsW'(Q4)) ? '0 : sq_w;
  always_comb begin
    if (p_w >= QsW'(3 * SINE_QUARTER_DEPTH)) begin
      quad_w = 2'd3;
      k_w    = p_w - QsW'(3 * SINE_QUARTER_DEPTH);
    end else if (p_w >= QsW'(2 * SINE_QUARTER_DEPTH)) begin
      quad_w = 2'd2;
      k_w    = p_w - QsW'(2 * SINE_QUARTER_DEPTH);
    end else if (p_w >= QsW'(SINE_QUARTER_DEPTH)) begin
      quad_w = 2'd1;
      k_w    = p_w - QsW'(SINE_QUARTER_DEPTH);
    end else begin
      quad_w = 2'd0;
      k_w    = p_w;
    end
  end
  assign rom_addr_w = quad_w[0] ? RomAW'(SINE_QUARTER_DEPTH) - RomAW'(k_w) : RomAW'(k_w);

  assign inext_w = {2'b00, div_rsp.quo[8:0]} + 11'd1;

  assign cfg_ready_o     = (state_q == ST_IDLE);
  assign s_axis_tready_o = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_take = cfg_valid_i && cfg_ready_o;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);

  // ---- control ----
  always_comb begin
    state_d = state_q;
    div_req = '0;
    ram_re  = 1'b0;
    ram_we  = 1'b0;
    rom_re  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_take) begin
          if (!cfg_index_i[3]) state_d = ST_DRD;
        end else if (in_take) begin
          state_d = ST_TRD;
        end
      end
      ST_TRD: begin
        ram_re  = 1'b1;
        state_d = ST_TEVAL;
      end
      ST_TEVAL: begin
        if (!tick_q) begin
          state_d = ch_q ? ST_OUT : ST_TRD;
        end else if (!hold_zero || cur_freq == '0 || !known_type) begin
          state_d = ST_TWR;
        end else if (cur_type == WaveSquare) begin
          state_d = ST_TMUL;
        end else begin
          div_req.start = 1'b1;
          div_req.dsor  = DivW'(ent.len);
          if (cur_type == WaveSine) begin
            div_req.dend  = DivW'(32'(phase_w) * Q4);
            div_req.steps = StepW'(QsW);
          end else begin
            div_req.dend  = DivW'({mag_w, 15'd0});
            div_req.steps = ShapeSteps;
          end
          state_d = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (div_rsp.done) begin
          state_d = sine_q ? ST_TROM : ST_TMUL;
        end
      end
      ST_TROM: begin
        rom_re  = 1'b1;
        state_d = ST_TMUL;
      end
      ST_TMUL: state_d = ST_TSCALE;
      ST_TSCALE: begin
        if (n2_w < 0 || n2_w >= ScaleLim) begin
          state_d = ST_TWR;
        end else begin
          state_d = ST_TFIN;
        end
      end
      ST_TFIN: state_d = ST_TWR;
      ST_TWR: begin
        ram_we  = 1'b1;
        state_d = ch_q ? ST_OUT : ST_TRD;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      ST_DRD: begin
        ram_re  = 1'b1;
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        if (cur_freq == '0) begin
          state_d = ST_DWR;
        end else begin
          div_req.start = 1'b1;
          div_req.steps = DeriveSteps;
          if (cur_freq > BaseRate) begin
            div_req.dend = FastNum;
            div_req.dsor = DivW'(cur_freq);
          end else begin
            div_req.dend = SearchNum;
            div_req.dsor = DivW'({cur_freq, 8'd0});
          end
          state_d = ST_DDIV1;
        end
      end
      ST_DDIV1: begin
        if (div_rsp.done) begin
          if (fast_q || inext_w >= 11'(MAX_HOLD)) state_d = ST_DWR;
          else                                    state_d = ST_DMUL;
        end
      end
      ST_DMUL: state_d = ST_DDIV2S;
      ST_DDIV2S: begin
        div_req.start = 1'b1;
        div_req.dend  = SearchNum;
        div_req.dsor  = DivW'(fi_q);
        div_req.steps = DeriveSteps;
        state_d       = ST_DDIV2;
      end
      ST_DDIV2: begin
        if (div_rsp.done) state_d = ST_DWR;
      end
      ST_DWR: begin
        ram_we  = 1'b1;
        state_d = ch_q ? ST_IDLE : ST_DRD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // write back word
  always_comb begin
    ram_wdata = ent;
    if (state_q == ST_DWR) begin
      ram_wdata.phase  = '0;
      ram_wdata.hold   = '0;
      ram_wdata.len    = len_q;
      ram_wdata.reload = rel_q;
      ram_wdata.held   = init_q ? FullCode : ent.held;
    end else if (upd_q) begin
      ram_wdata.phase = phase_q + 9'd1;
      ram_wdata.hold  = ent.reload;
      ram_wdata.held  = sample_q;
    end else begin
      ram_wdata.phase = phase_q;
      ram_wdata.hold  = ent.hold - 10'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DRD;
      ch_q        <= 1'b0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        type_q[c] <= WaveSine;
        amp_q[c]  <= 11'd300;
        off_q[c]  <= 11'd300;
        freq_q[c] <= 16'd1000;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        ch_q <= 1'b0;
      end else if (state_q == ST_TWR || state_q == ST_DWR ||
                   (state_q == ST_TEVAL && !tick_q)) begin
        ch_q <= ~ch_q;
      end
      if (state_q == ST_DWR && ch_q) begin
        init_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_take && !cfg_index_i[3]) begin
        unique case (cfg_index_i[1:0])
          RegType: type_q[cfg_index_i[2]] <= cfg_data_i[TypeW-1:0];
          RegAmp:  amp_q[cfg_index_i[2]]  <= cfg_data_i[AmpW-1:0];
          RegOff:  off_q[cfg_index_i[2]]  <= cfg_data_i[AmpW-1:0];
          RegFreq: freq_q[cfg_index_i[2]] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tick_q <= s_axis_tdata_i[0];
    end
    if (out_load) begin
      out_data_q <= {smp_q[1], smp_q[0]};
    end
    unique case (state_q)
      ST_TEVAL: begin
        phase_q <= phase_w;
        upd_q   <= hold_zero;
        sine_q  <= (cur_type == WaveSine);
        neg_q   <= num_w[11];
        s_q     <= sq_high ? 19'sd32768 : -19'sd32768;
        if (cur_freq == '0) sample_q <= MidCode;
        else                sample_q <= '0;
        if (!tick_q) smp_q[ch_q] <= ent.held;
      end
      ST_TDIV: begin
        if (div_rsp.done) begin
          if (sine_q) begin
            neg_q      <= quad_w[1];
            rom_addr_q <= rom_addr_w;
          end else begin
            s_q <= neg_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
          end
        end
      end
      ST_TMUL: begin
        if (sine_q) begin
          s_q    <= neg_q ? -$signed({4'b0000, rom_data}) : $signed({4'b0000, rom_data});
          prod_q <= $signed({1'b0, cur_amp}) *
                    (neg_q ? -$signed({4'b0000, rom_data}) : $signed({4'b0000, rom_data}));
        end else begin
          prod_q <= s_q * $signed({1'b0, cur_amp});
        end
      end
      ST_TSCALE: begin
        if (n2_w < 0)              sample_q <= '0;
        else if (n2_w >= ScaleLim) sample_q <= FullCode;
        else                       scl_q    <= n2_w[32:17];
      end
      ST_TFIN: begin
        sample_q <= recip_w[30:23];
      end
      ST_TWR: begin
        smp_q[ch_q] <= upd_q ? sample_q : ent.held;
      end
      ST_DSTART: begin
        fast_q <= (cur_freq > BaseRate);
        len_q  <= 9'd1;
        rel_q  <= '0;
      end
      ST_DDIV1: begin
        if (div_rsp.done) begin
          iq_q <= inext_w[8:0];
          if (fast_q) begin
            len_q <= div_rsp.quo[8:0];
            rel_q <= '0;
          end else if (inext_w >= 11'(MAX_HOLD)) begin
            len_q <= 9'd255;
            rel_q <= 10'(MAX_HOLD - 1);
          end
        end
      end
      ST_DMUL: begin
        fi_q <= 18'(cur_freq[8:0]) * 18'(iq_q);
      end
      ST_DDIV2: begin
        if (div_rsp.done) begin
          len_q <= div_rsp.quo[8:0];
          rel_q <= 10'(iq_q - 9'd1);
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  dcwg_state_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ch_q),
    .rdata_o (ent)
  );

  dcwg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dcwg_sine_rom #(
    .SINE_QUARTER_DEPTH (SINE_QUARTER_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .re_i   (rom_re),
    .addr_i (rom_addr_q),
    .data_o (rom_data)
  );

endmodule

`default_nettype wire

FILE: sv/dcwg_checker.sv
// Port level checks for the waveform generator, bound to the top level.
// Sees only the top level ports; no package use.
`timescale 1ns / 1ps
`default_nettype none

module dcwg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [7:0]  s_axis_tdata_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [3:0]  cfg_index_i,
  input wire logic [15:0] cfg_data_i
);

  // one beat in work at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after a beat");

  // a register write restarts derivation, so input stalls
  a_busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && !cfg_index_i[3]) |=> !s_axis_tready_o)
    else $error("input ready right after a register write");

  a_ready_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> cfg_ready_o)
    else $error("input ready while config port busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("output beat dropped or changed while stalled");

endmodule

bind dual_channel_waveform_generator_top dcwg_checker u_dcwg_checker (.*);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking bench for dual_channel_waveform_generator_top: tick beats in,
// sample pairs out, checked against a cycle-free model of both channels.
// Depends on dcwg_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb;
  import dcwg_pkg::*;

  localparam int QDepth    = 256;
  localparam int HoldMax   = 1000;
  localparam int SettleCyc = 200;
  localparam int StallLim  = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  dual_channel_waveform_generator_top u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // channel model, index 0 is channel A
  int   quarter_sine [QDepth+1];
  int   wtype [2], amp [2], offs [2], freq [2];
  int   phase [2], hold [2], plen [2], reload [2], held [2];
  bit   tick_q [$];
  logic [15:0] sample_q [$];
  int   errors = 0;

  function automatic int sine_q15(int k);
    longint unsigned x, x2, term, v;
    longint          sum;
    x = (64'd1686629713 * longint'(k)) / QDepth;
    x2 = (x * x) >> 30;
    term = x;
    sum = 0;
    for (int n = 1; n <= 13; n += 2) begin
      if (((n >> 1) & 1) != 0) sum -= longint'(term);
      else sum += longint'(term);
      term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
    end
    if (sum < 0) sum = 0;
    v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
    if (v > 32767) v = 32767;
    return int'(v);
  endfunction

  function automatic void derive_period(int c);
    int i;
    if (freq[c] == 0) begin
      plen[c] = 1; reload[c] = 0;
    end else if (freq[c] <= 410) begin
      i = 104550 / (256 * freq[c]) + 1;
      if (i < HoldMax) begin
        plen[c] = 104550 / (freq[c] * i); reload[c] = i - 1;
      end else begin
        plen[c] = 255; reload[c] = HoldMax - 1;
      end
    end else begin
      plen[c] = 104960 / freq[c]; reload[c] = 0;
    end
  endfunction

  function automatic void restart_channels();
    for (int c = 0; c < 2; c++) begin
      derive_period(c);
      phase[c] = 0; hold[c] = 0;
    end
  endfunction

  function automatic int dac_code(int c, int i);
    longint li, ll, num, n2, den;
    int     s, p, q, k, v, len;
    len = plen[c];
    li = i; ll = len;
    den = 300 * 32768;
    if (freq[c] == 0) return 127;
    case (wtype[c][TypeW-1:0])
      WaveSine: begin
        p = ((i * 4 * QDepth) / len) % (4 * QDepth);
        q = p / QDepth; k = p % QDepth;
        v = (q & 1) ? quarter_sine[QDepth - k] : quarter_sine[k];
        s = (q >= 2) ? -v : v;
      end
      WaveSquare: s = (i < len / 2) ? 32768 : -32768;
      WaveTriangle: begin
        if (i < len / 4) num = 4 * li;
        else if (i < (3 * len) / 4) num = 2 * ll - 4 * li;
        else num = 4 * li - 4 * ll;
        s = int'((num * 32768) / ll);
      end
      WaveSaw: begin
        num = (i < len / 2) ? 2 * li : 2 * li - 2 * ll;
        s = int'((num * 32768) / ll);
      end
      WaveRevSaw: s = int'(((ll - 2 * li) * 32768) / ll);
      default: return 0;
    endcase
    num = 128 * longint'(s) * amp[c] + 127 * 32768 * longint'(offs[c]);
    n2 = 2 * num + den;
    if (n2 < 0) return 0;
    n2 = n2 / (2 * den);
    return (n2 > 255) ? 255 : int'(n2);
  endfunction

  function automatic void tick_channel(int c);
    if (phase[c] > plen[c]) phase[c] -= plen[c];
    if (hold[c] == 0) begin
      held[c] = dac_code(c, phase[c]);
      hold[c] = reload[c];
      phase[c] = (phase[c] + 1) & 9'h1FF;
    end else begin
      hold[c] -= 1;
    end
  endfunction

  function automatic void write_register(int idx, int val);
    int c;
    if (idx > 7) return;
    c = idx >> 2;
    case (idx[1:0])
      RegType: wtype[c] = val & 7;
      RegAmp:  amp[c] = val & 11'h7FF;
      RegOff:  offs[c] = val & 11'h7FF;
      RegFreq: freq[c] = val & 16'hFFFF;
      default: ;
    endcase
    restart_channels();
  endfunction

  // driver: bursts of beats separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (tick_q.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {7'b0, tick_q.pop_front()};
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: picks among stall patterns, one of which never stalls
  int rdy_cnt = 0, rdy_mode = 0;
  always @(posedge clk_i) begin
    rdy_cnt <= rdy_cnt + 1;
    if (rdy_cnt % 64 == 0) rdy_mode <= $urandom_range(0, 3);
    case (rdy_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready_i <= ($urandom_range(0, 1) != 0);
      default: m_axis_tready_i <= (rdy_cnt % 8 < 2);
    endcase
  end

  // monitor: track writes and ticks, check sample beats, watch for hangs
  int quiet = 0;
  always @(posedge clk_i) begin
    logic [15:0] want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (sample_q.size() == 0) begin
        $error("unexpected sample beat %h", m_axis_tdata_o);
        errors++;
      end else begin
        want = sample_q.pop_front();
        if (m_axis_tdata_o[7:0] !== want[7:0]) begin
          $error("sample_a expected %0d actual %0d", want[7:0], m_axis_tdata_o[7:0]);
          errors++;
        end
        if (m_axis_tdata_o[15:8] !== want[15:8]) begin
          $error("sample_b expected %0d actual %0d", want[15:8], m_axis_tdata_o[15:8]);
          errors++;
        end
      end
    end
    if (cfg_valid_i && cfg_ready_o) write_register(cfg_index_i, cfg_data_i);
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      if (s_axis_tdata_i[0]) begin
        tick_channel(0);
        tick_channel(1);
      end
      sample_q.push_back({held[1][7:0], held[0][7:0]});
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= StallLim) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic cfg_write(int idx, int val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[3:0];
    cfg_data_i <= val[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (tick_q.size() > 0 || s_axis_tvalid_i || sample_q.size() > 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic queue_ticks(int n, int pct_one);
    for (int k = 0; k < n; k++) tick_q.push_back($urandom_range(0, 99) < pct_one);
  endtask

  function automatic int pick_freq();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return $urandom_range(1, 410);
      2: return $urandom_range(1, 20);
      3: return $urandom_range(411, 3000);
      4: return $urandom_range(3001, 65535);
      5: return 65535;
      default: return $urandom_range(400, 420);
    endcase
  endfunction

  function automatic int pick_code();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 2047;
      2: return $urandom_range(0, 600);
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  initial begin
    for (int k = 0; k <= QDepth; k++) quarter_sine[k] = sine_q15(k);
    for (int c = 0; c < 2; c++) begin
      wtype[c] = WaveSine; amp[c] = 300; offs[c] = 300; freq[c] = 1000;
      held[c] = 255;
    end
    restart_channels();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting, including idle ticks
    tick_q.push_back(1'b0);
    queue_ticks(7, 100);
    drain();
    // extremes: square full swing at the hold boundary, unknown type, zero frequency
    cfg_write(0, WaveSquare);  cfg_write(1, 2047); cfg_write(2, 0);    cfg_write(3, 410);
    cfg_write(4, 0);           cfg_write(5, 0);    cfg_write(6, 2047); cfg_write(7, 0);
    cfg_write(8, 16'hFFFF);    cfg_write(15, 0);
    queue_ticks(8, 100);
    drain();
    cfg_write(0, WaveTriangle); cfg_write(3, 65535); cfg_write(2, 2047);
    cfg_write(4, WaveSaw);      cfg_write(5, 2047);  cfg_write(6, 300); cfg_write(7, 1);
    queue_ticks(4, 100);
    drain();
    cfg_write(0, WaveRevSaw); cfg_write(3, 411); cfg_write(4, 7); cfg_write(7, 5000);
    queue_ticks(5, 100);
    drain();

    // random settings, mostly running ticks
    for (int ph = 0; ph < 10; ph++) begin
      for (int r = 0; r < 8; r++) begin
        if (ph == 0 || $urandom_range(0, 1) == 0) begin
          case (r & 3)
            0: cfg_write(r, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                        : $urandom_range(1, 5));
            3: cfg_write(r, pick_freq());
            default: cfg_write(r, pick_code());
          endcase
        end
      end
      if ($urandom_range(0, 4) == 0) cfg_write($urandom_range(8, 15), $urandom_range(0, 65535));
      queue_ticks(100, 85);
      drain();
    end

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
